// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the DNS query classifier RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define DQC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define DQC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- hw/rtl/dqc_pkg.sv -----
// ----------------------------------------------------------------------------
// dqc_pkg
// Types and constants shared by the DNS query classifier modules.
// ----------------------------------------------------------------------------
package dqc_pkg;

    // Name and offset limits
    localparam int unsigned NAME_LIMIT  = 256;
    localparam int unsigned NAME_W      = 9;
    localparam int unsigned SUM_W       = NAME_W + 1;
    localparam int unsigned OFFSET_BITS = 11;
    localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = '1;

    // Header byte positions (frame offset of the byte)
    localparam int unsigned OFS_ETYPE_HI = 12;
    localparam int unsigned OFS_ETYPE_LO = 13;
    localparam int unsigned OFS_PROTO    = 23;
    localparam int unsigned OFS_IP_END   = 33;
    localparam int unsigned OFS_DPORT_HI = 36;
    localparam int unsigned OFS_DPORT_LO = 37;
    localparam int unsigned OFS_UDP_END  = 41;
    localparam int unsigned OFS_FLAGS_HI = 44;
    localparam int unsigned OFS_QDCNT_HI = 46;
    localparam int unsigned OFS_QDCNT_LO = 47;
    localparam int unsigned OFS_DNS_END  = 53;

    // Field values
    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [15:0] PROTO_UDP      = 16'd17;
    localparam int unsigned QR_BIT         = 15;
    localparam logic [15:0] QDCOUNT_ONE    = 16'd1;
    localparam logic [15:0] QTYPE_A        = 16'd1;
    localparam logic [15:0] QTYPE_AAAA     = 16'd28;
    localparam logic [15:0] QCLASS_IN      = 16'd1;
    localparam logic [7:0]  DOT_CHAR       = 8'h2E;

    // Question byte positions
    localparam logic [1:0] QO_TYPE_HI  = 2'd0;
    localparam logic [1:0] QO_TYPE_LO  = 2'd1;
    localparam logic [1:0] QO_CLASS_HI = 2'd2;
    localparam logic [1:0] QO_CLASS_LO = 2'd3;

    // Result queue
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);

    // Register port
    localparam int unsigned APB_ADDR_W = 3;
    localparam int unsigned APB_DATA_W = 32;
    localparam logic [0:0]  REG_DNS_PORT   = 1'b0;
    localparam logic [15:0] DNS_PORT_RESET = 16'd53;

    typedef enum logic [3:0] {
        ST_OK     = 4'd0,
        ST_SHORT  = 4'd1,
        ST_NOTIP  = 4'd2,
        ST_NOTUDP = 4'd3,
        ST_PORT   = 4'd4,
        ST_RESP   = 4'd5,
        ST_QDCNT  = 4'd6,
        ST_NAME   = 4'd7,
        ST_QTYPE  = 4'd8,
        ST_QCLASS = 4'd9
    } t_status;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       frame_last;
    } t_in_item;

    typedef struct packed {
        logic              kind;
        logic [7:0]        name_char;
        logic [3:0]        status;
        logic [15:0]       query_type;
        logic [NAME_W-1:0] name_length;
        logic              last;
    } t_out_item;

    // Up to two results per byte, first one in item0
    typedef struct packed {
        logic [1:0] count;
        t_out_item  item0;
        t_out_item  item1;
    } t_push;

endpackage

// ----- hw/rtl/dns_query_classifier.sv -----
// ----------------------------------------------------------------------------
// dns_query_classifier
// Byte-stream DNS query classifier with an APB register for the DNS port.
// ----------------------------------------------------------------------------
// The block takes an Ethernet frame one byte per transfer, starting at the
// destination MAC, and accepts a new byte every cycle. Each byte passes an
// input register, then combinational parse logic that writes its results
// into a four-entry result queue. Most bytes give zero or one result; a byte
// that opens a label after the first (separator dot) or carries a name
// character and is also the last byte of the frame gives two, and those
// drain at one per cycle while the consumer is ready. The input side stalls
// only when the result queue has fewer than two free entries, which with a
// ready consumer happens only after such two-result bytes. Results are name
// characters (kind 0) in dotted form, then one verdict item (kind 1, last 1)
// with the status code, the captured qtype and the name length (label bytes
// plus one per label). The header is taken to be a fixed 20-byte IPv4 header.
// The UDP destination port to match sits at register 0 (byte address 0,
// reset 53); write it only while no frame is in flight. No memory needs
// clearing after reset: the block is ready as soon as reset is released.
// ----------------------------------------------------------------------------
module dns_query_classifier (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // byte input
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  dqc_pkg::t_in_item                i_in_data,
    // result output
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output dqc_pkg::t_out_item               o_out_data,
    // register port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [dqc_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [dqc_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [dqc_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready
);

    logic [15:0]       r_dns_port;
    logic              r_in_valid;
    dqc_pkg::t_in_item r_in_item;

    logic              in_xfer;
    logic              consume;
    logic              q_can_take;
    logic              reg_write;
    logic [0:0]        reg_index;
    dqc_pkg::t_push    push;

    // Register port: never waits (pready tied high), port register at index 0 only.
    assign pready    = 1'b1;
    assign reg_index = paddr[dqc_pkg::APB_ADDR_W-1:2];
    assign reg_write = psel && penable && pwrite;
    assign prdata    = (reg_index == dqc_pkg::REG_DNS_PORT) ?
                       {{(dqc_pkg::APB_DATA_W - 16){1'b0}}, r_dns_port} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dns_port <= dqc_pkg::DNS_PORT_RESET;
        end else if (reg_write && reg_index == dqc_pkg::REG_DNS_PORT) begin
            r_dns_port <= pwdata[15:0];
        end
    end

    // Input register: advance the held byte into the parser whenever the
    // result queue can take the worst case of two results.
    assign consume    = r_in_valid && q_can_take;
    assign o_in_ready = !r_in_valid || consume;
    assign in_xfer    = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= in_xfer || (r_in_valid && !consume);
        end
    end

    // Hold the payload until it is consumed.
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_item <= i_in_data;
        end
    end

    dqc_parser u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (consume),
        .i_item     (r_in_item),
        .i_dns_port (r_dns_port),
        .o_push     (push)
    );

    // Result queue decouples the two sides; drop nothing, one out per cycle while the consumer is ready.
    dqc_out_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_ready    (i_out_ready),
        .o_valid    (o_out_valid),
        .o_item     (o_out_data),
        .o_can_take (q_can_take)
    );

endmodule

// ----- hw/rtl/dqc_parser.sv -----
// ----------------------------------------------------------------------------
// dqc_parser
// Per-byte frame parser: header checks, name walk, question checks, verdict.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dqc_parser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  dqc_pkg::t_in_item i_item,
    input  logic [15:0]      i_dns_port,
    output dqc_pkg::t_push   o_push
);

    typedef enum logic [6:0] {
        PH_HDR   = 7'b0000001,
        PH_LEN   = 7'b0000010,
        PH_LABEL = 7'b0000100,
        PH_SKIP  = 7'b0001000,
        PH_QUES  = 7'b0010000,
        PH_DONE  = 7'b0100000,
        PH_FAIL  = 7'b1000000
    } t_phase;

    logic [dqc_pkg::OFFSET_BITS-1:0] r_byte_offset, n_byte_offset;
    t_phase                          r_phase, n_phase;
    logic [7:0]                      r_label_rem, n_label_rem;
    logic [dqc_pkg::NAME_W-1:0]      r_name_count, n_name_count;
    dqc_pkg::t_status                r_first_status, n_first_status;
    logic [15:0]                     r_field_hold, n_field_hold;
    logic [15:0]                     r_type_hold, n_type_hold;
    logic [1:0]                      r_ques_ofs, n_ques_ofs;

    logic [7:0]                  b;
    logic [dqc_pkg::SUM_W-1:0]   len_sum;
    logic [dqc_pkg::NAME_W-1:0]  label_end_count;
    dqc_pkg::t_status            end_code;
    dqc_pkg::t_status            verdict_st;
    logic                        char_valid;
    logic [7:0]                  char_byte;
    dqc_pkg::t_out_item          char_item;
    dqc_pkg::t_out_item          verdict_item;

    assign b       = i_item.frame_byte;
    assign len_sum = dqc_pkg::SUM_W'(r_name_count) + dqc_pkg::SUM_W'(b)
                   + dqc_pkg::SUM_W'(1);
    assign label_end_count = r_name_count + dqc_pkg::NAME_W'(2);

    always_comb begin
        n_byte_offset  = r_byte_offset;
        n_phase        = r_phase;
        n_label_rem    = r_label_rem;
        n_name_count   = r_name_count;
        n_first_status = r_first_status;
        n_field_hold   = r_field_hold;
        n_type_hold    = r_type_hold;
        n_ques_ofs     = r_ques_ofs;
        end_code       = dqc_pkg::ST_SHORT;
        char_valid     = 1'b0;
        char_byte      = b;

        unique case (r_phase)
            PH_HDR: begin
                unique case (r_byte_offset) inside
                    dqc_pkg::OFFSET_BITS'(dqc_pkg::OFS_ETYPE_HI),
                    dqc_pkg::OFFSET_BITS'(dqc_pkg::OFS_DPORT_HI),
                    dqc_pkg::OFFSET_BITS'(dqc_pkg::OFS_QDCNT_HI): begin
                        n_field_hold = {b, 8'h00};
                    end
                    dqc_pkg::OFFSET_BITS'(dqc_pkg::OFS_ETYPE_LO): begin
                        n_field_hold = {r_field_hold[15:8], b};
                        if (n_field_hold != dqc_pkg::ETHERTYPE_IPV4) begin
                            n_first_status = dqc_pkg::ST_NOTIP;
                            n_phase        = PH_FAIL;
                        end
                    end
                    dqc_pkg::OFFSET_BITS'(dqc_pkg::OFS_PROTO): begin
                        n_field_hold = {8'h00, b};
                    end
                    dqc_pkg::OFFSET_BITS'(dqc_pkg::OFS_IP_END): begin
                        if (r_field_hold != dqc_pkg::PROTO_UDP) begin
                            n_first_status = dqc_pkg::ST_NOTUDP;
                            n_phase        = PH_FAIL;
                        end
                    end
                    dqc_pkg::OFFSET_BITS'(dqc_pkg::OFS_DPORT_LO),
                    dqc_pkg::OFFSET_BITS'(dqc_pkg::OFS_QDCNT_LO): begin
                        n_field_hold = {r_field_hold[15:8], b};
                    end
                    dqc_pkg::OFFSET_BITS'(dqc_pkg::OFS_UDP_END): begin
                        if (r_field_hold != i_dns_port) begin
                            n_first_status = dqc_pkg::ST_PORT;
                            n_phase        = PH_FAIL;
                        end
                    end
                    dqc_pkg::OFFSET_BITS'(dqc_pkg::OFS_FLAGS_HI): begin
                        n_type_hold = {b, 8'h00};
                    end
                    dqc_pkg::OFFSET_BITS'(dqc_pkg::OFS_DNS_END): begin
                        if (r_type_hold[dqc_pkg::QR_BIT]) begin
                            n_first_status = dqc_pkg::ST_RESP;
                            n_phase        = PH_FAIL;
                        end else if (r_field_hold != dqc_pkg::QDCOUNT_ONE) begin
                            n_first_status = dqc_pkg::ST_QDCNT;
                            n_phase        = PH_FAIL;
                        end else begin
                            n_phase     = PH_LEN;
                            n_type_hold = '0;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            PH_LEN: begin
                if (b == 8'd0) begin
                    n_phase    = PH_QUES;
                    n_ques_ofs = dqc_pkg::QO_TYPE_HI;
                end else if (len_sum > dqc_pkg::SUM_W'(dqc_pkg::NAME_LIMIT)) begin
                    n_first_status = dqc_pkg::ST_NAME;
                    n_phase        = PH_FAIL;
                end else begin
                    // separator before every label but the first
                    char_valid  = (r_name_count != '0);
                    char_byte   = dqc_pkg::DOT_CHAR;
                    n_label_rem = b;
                    n_phase     = PH_LABEL;
                    end_code    = dqc_pkg::ST_NAME;
                end
            end
            PH_LABEL: begin
                char_valid  = 1'b1;
                n_label_rem = r_label_rem - 8'd1;
                if (n_label_rem == 8'd0) begin
                    n_name_count = label_end_count;
                    n_phase = (dqc_pkg::SUM_W'(label_end_count)
                               >= dqc_pkg::SUM_W'(dqc_pkg::NAME_LIMIT)) ? PH_SKIP : PH_LEN;
                end else begin
                    n_name_count = r_name_count + dqc_pkg::NAME_W'(1);
                    end_code     = dqc_pkg::ST_NAME;
                end
            end
            PH_SKIP: begin
                // name hit the limit: treat this byte as the terminator
                n_phase    = PH_QUES;
                n_ques_ofs = dqc_pkg::QO_TYPE_HI;
            end
            PH_QUES: begin
                case (r_ques_ofs)
                    dqc_pkg::QO_TYPE_HI:  n_type_hold  = {b, 8'h00};
                    dqc_pkg::QO_TYPE_LO:  n_type_hold  = {r_type_hold[15:8], b};
                    dqc_pkg::QO_CLASS_HI: n_field_hold = {b, 8'h00};
                    dqc_pkg::QO_CLASS_LO: begin
                        n_field_hold = {r_field_hold[15:8], b};
                        if (r_type_hold != dqc_pkg::QTYPE_A &&
                            r_type_hold != dqc_pkg::QTYPE_AAAA) begin
                            n_first_status = dqc_pkg::ST_QTYPE;
                            n_phase        = PH_FAIL;
                        end else if (n_field_hold != dqc_pkg::QCLASS_IN) begin
                            n_first_status = dqc_pkg::ST_QCLASS;
                            n_phase        = PH_FAIL;
                        end else begin
                            n_phase = PH_DONE;
                        end
                    end
                endcase
                n_ques_ofs = r_ques_ofs + 2'd1;
            end
            default: begin
                // done or failed: ignore bytes until the last one
            end
        endcase

        if (r_byte_offset != dqc_pkg::OFFSET_MAX) begin
            n_byte_offset = r_byte_offset + dqc_pkg::OFFSET_BITS'(1);
        end

        // verdict from the updated state
        if (n_phase == PH_FAIL) begin
            verdict_st = n_first_status;
        end else if (n_phase == PH_DONE) begin
            verdict_st = dqc_pkg::ST_OK;
        end else begin
            verdict_st = end_code;
        end

        char_item             = '0;
        char_item.name_char   = char_byte;

        verdict_item             = '0;
        verdict_item.kind        = 1'b1;
        verdict_item.status      = verdict_st;
        verdict_item.query_type  = (verdict_st == dqc_pkg::ST_OK ||
                                    verdict_st == dqc_pkg::ST_QTYPE ||
                                    verdict_st == dqc_pkg::ST_QCLASS) ? n_type_hold : 16'd0;
        verdict_item.name_length = n_name_count;
        verdict_item.last        = 1'b1;

        o_push = '0;
        if (i_fire) begin
            if (char_valid) begin
                o_push.item0 = char_item;
                o_push.item1 = verdict_item;
                o_push.count = i_item.frame_last ? 2'd2 : 2'd1;
            end else begin
                o_push.item0 = verdict_item;
                o_push.count = i_item.frame_last ? 2'd1 : 2'd0;
            end
        end

        // start over after the verdict
        if (i_item.frame_last) begin
            n_byte_offset  = '0;
            n_phase        = PH_HDR;
            n_label_rem    = '0;
            n_name_count   = '0;
            n_first_status = dqc_pkg::ST_OK;
            n_field_hold   = '0;
            n_type_hold    = '0;
            n_ques_ofs     = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_offset  <= '0;
            r_phase        <= PH_HDR;
            r_label_rem    <= '0;
            r_name_count   <= '0;
            r_first_status <= dqc_pkg::ST_OK;
            r_field_hold   <= '0;
            r_type_hold    <= '0;
            r_ques_ofs     <= '0;
        end else if (i_fire) begin
            r_byte_offset  <= n_byte_offset;
            r_phase        <= n_phase;
            r_label_rem    <= n_label_rem;
            r_name_count   <= n_name_count;
            r_first_status <= n_first_status;
            r_field_hold   <= n_field_hold;
            r_type_hold    <= n_type_hold;
            r_ques_ofs     <= n_ques_ofs;
        end
    end

    `DQC_ASSERT(a_last_restarts, (i_fire && i_item.frame_last) |=> (r_byte_offset == '0 && r_phase == PH_HDR), "frame did not restart after verdict")
    `DQC_ASSERT(a_verdict_trails, (o_push.count == 2'd2) |-> (!o_push.item0.kind && o_push.item1.kind), "verdict not after character")
    `DQC_ASSERT(a_name_bound, dqc_pkg::SUM_W'(r_name_count) <= dqc_pkg::SUM_W'(dqc_pkg::NAME_LIMIT), "name count above limit")
    `DQC_ASSERT(a_push_needs_fire, (o_push.count != 2'd0) |-> i_fire, "result without accepted byte")

endmodule

// ----- hw/rtl/dqc_out_queue.sv -----
// ----------------------------------------------------------------------------
// dqc_out_queue
// Small result queue: takes up to two results a cycle, gives one a cycle while the consumer is ready.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dqc_out_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  dqc_pkg::t_push     i_push,
    input  logic               i_ready,
    output logic               o_valid,
    output dqc_pkg::t_out_item o_item,
    output logic               o_can_take
);

    dqc_pkg::t_out_item r_mem [dqc_pkg::QUEUE_DEPTH];

    logic [dqc_pkg::PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [dqc_pkg::PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [dqc_pkg::CNT_W-1:0] r_count, n_count;
    logic                      pop;

    assign o_valid    = (r_count != '0);
    assign o_item     = r_mem[r_rd_ptr];
    assign o_can_take = (r_count <= dqc_pkg::CNT_W'(dqc_pkg::QUEUE_DEPTH - 2));
    assign pop        = o_valid && i_ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr + dqc_pkg::PTR_W'(i_push.count);
        n_rd_ptr = r_rd_ptr + dqc_pkg::PTR_W'(pop);
        n_count  = r_count + dqc_pkg::CNT_W'(i_push.count) - dqc_pkg::CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.item0;
        end
        if (i_push.count == 2'd2) begin
            r_mem[r_wr_ptr + dqc_pkg::PTR_W'(1)] <= i_push.item1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    `DQC_ASSERT(a_no_overflow, (i_push.count != 2'd0) |-> o_can_take, "push into full queue")
    `DQC_ASSERT(a_count_bound, r_count <= dqc_pkg::CNT_W'(dqc_pkg::QUEUE_DEPTH), "queue count above depth")
    `DQC_ASSERT(a_pop_drains, (pop && i_push.count == 2'd0) |=> (r_count == $past(r_count) - dqc_pkg::CNT_W'(1)), "pop did not drain")
    `DQC_ASSERT(a_ptr_gap, (r_wr_ptr - r_rd_ptr) == dqc_pkg::PTR_W'(r_count), "pointers disagree with count")

endmodule

// ----- dv/dqc_result_checker.sv -----
// ----------------------------------------------------------------------------
// dqc_result_checker
// Watches the byte, result and register channels of the DNS query classifier.
// It parses each accepted byte with its own copy of the frame state, queues
// the name characters and verdicts that byte must produce, and compares every
// accepted result with the oldest queued one.
// ----------------------------------------------------------------------------
module dqc_result_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_ready,
    input  dqc_pkg::t_in_item              i_in_data,
    input  logic                           i_out_valid,
    input  logic                           i_out_ready,
    input  dqc_pkg::t_out_item             i_out_data,
    input  logic                           i_psel,
    input  logic                           i_penable,
    input  logic                           i_pwrite,
    input  logic                           i_pready,
    input  logic [dqc_pkg::APB_ADDR_W-1:0] i_paddr,
    input  logic [dqc_pkg::APB_DATA_W-1:0] i_pwdata,
    output int                             o_mismatches,
    output int                             o_pending,
    output int                             o_frames,
    output int                             o_chars,
    output logic [15:0]                    o_status_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [dqc_pkg::APB_ADDR_W-1:0] DNS_PORT_ADDR =
        dqc_pkg::APB_ADDR_W'(4 * dqc_pkg::REG_DNS_PORT);

    typedef enum logic [6:0] {
        PH_HEADER   = 7'b0000001,
        PH_LENGTH   = 7'b0000010,
        PH_LABEL    = 7'b0000100,
        PH_SKIP     = 7'b0001000,
        PH_QUESTION = 7'b0010000,
        PH_DONE     = 7'b0100000,
        PH_FAILED   = 7'b1000000
    } t_parse_phase;

    logic [15:0]                     port_cfg;
    logic [dqc_pkg::OFFSET_BITS-1:0] offset;
    t_parse_phase                    phase;
    logic [7:0]                      label_left;
    logic [dqc_pkg::NAME_W-1:0]      name_count;
    dqc_pkg::t_status                first_fail;
    logic [15:0]                     field_hold;
    logic [15:0]                     type_hold;
    logic [2:0]                      ques_pos;
    dqc_pkg::t_out_item              expected_results[$];

    task automatic clear_frame_state();
        offset     = '0;
        phase      = PH_HEADER;
        label_left = '0;
        name_count = '0;
        first_fail = dqc_pkg::ST_OK;
        field_hold = '0;
        type_hold  = '0;
        ques_pos   = '0;
    endtask

    task automatic fail_frame(input dqc_pkg::t_status code);
        first_fail = code;
        phase      = PH_FAILED;
    endtask

    function automatic dqc_pkg::t_out_item char_item(input logic [7:0] c);
        dqc_pkg::t_out_item it;
        it = '0;
        it.name_char = c;
        return it;
    endfunction

    task automatic header_byte(input logic [7:0] b);
        case (int'(offset))
            dqc_pkg::OFS_ETYPE_HI: field_hold = {b, 8'h00};
            dqc_pkg::OFS_ETYPE_LO: begin
                field_hold = field_hold | {8'h00, b};
                if (field_hold != dqc_pkg::ETHERTYPE_IPV4) fail_frame(dqc_pkg::ST_NOTIP);
            end
            dqc_pkg::OFS_PROTO:    field_hold = {8'h00, b};
            dqc_pkg::OFS_IP_END:
                if (field_hold != dqc_pkg::PROTO_UDP) fail_frame(dqc_pkg::ST_NOTUDP);
            dqc_pkg::OFS_DPORT_HI: field_hold = {b, 8'h00};
            dqc_pkg::OFS_DPORT_LO: field_hold = field_hold | {8'h00, b};
            dqc_pkg::OFS_UDP_END:  if (field_hold != port_cfg) fail_frame(dqc_pkg::ST_PORT);
            dqc_pkg::OFS_FLAGS_HI: type_hold = {b, 8'h00};
            dqc_pkg::OFS_QDCNT_HI: field_hold = {b, 8'h00};
            dqc_pkg::OFS_QDCNT_LO: field_hold = field_hold | {8'h00, b};
            dqc_pkg::OFS_DNS_END: begin
                if (type_hold[dqc_pkg::QR_BIT]) begin
                    fail_frame(dqc_pkg::ST_RESP);
                end else if (field_hold != dqc_pkg::QDCOUNT_ONE) begin
                    fail_frame(dqc_pkg::ST_QDCNT);
                end else begin
                    phase     = PH_LENGTH;
                    type_hold = '0;
                end
            end
            default: ;
        endcase
    endtask

    // Advance the frame state by one byte and queue what it produces.
    task automatic classify_byte(input logic [7:0] b, input logic lst);
        dqc_pkg::t_status   end_code;
        dqc_pkg::t_status   verdict;
        dqc_pkg::t_out_item v;
        end_code = dqc_pkg::ST_SHORT;
        case (phase)
            PH_HEADER: header_byte(b);
            PH_LENGTH: begin
                if (b == 8'h00) begin
                    phase    = PH_QUESTION;
                    ques_pos = '0;
                end else if (int'(name_count) + int'(b) + 1 > dqc_pkg::NAME_LIMIT) begin
                    fail_frame(dqc_pkg::ST_NAME);
                end else begin
                    if (name_count != 0)
                        expected_results.push_back(char_item(dqc_pkg::DOT_CHAR));
                    label_left = b;
                    phase      = PH_LABEL;
                    end_code   = dqc_pkg::ST_NAME;
                end
            end
            PH_LABEL: begin
                expected_results.push_back(char_item(b));
                name_count = name_count + 1'b1;
                label_left = label_left - 1'b1;
                if (label_left == 0) begin
                    name_count = name_count + 1'b1;
                    if (name_count >= dqc_pkg::NAME_LIMIT) phase = PH_SKIP;
                    else phase = PH_LENGTH;
                end else begin
                    end_code = dqc_pkg::ST_NAME;
                end
            end
            PH_SKIP: begin
                phase    = PH_QUESTION;
                ques_pos = '0;
            end
            PH_QUESTION: begin
                case (ques_pos)
                    dqc_pkg::QO_TYPE_HI:  type_hold = {b, 8'h00};
                    dqc_pkg::QO_TYPE_LO:  type_hold = type_hold | {8'h00, b};
                    dqc_pkg::QO_CLASS_HI: field_hold = {b, 8'h00};
                    default: begin
                        field_hold = field_hold | {8'h00, b};
                        if (type_hold != dqc_pkg::QTYPE_A && type_hold != dqc_pkg::QTYPE_AAAA)
                            fail_frame(dqc_pkg::ST_QTYPE);
                        else if (field_hold != dqc_pkg::QCLASS_IN)
                            fail_frame(dqc_pkg::ST_QCLASS);
                        else
                            phase = PH_DONE;
                    end
                endcase
                ques_pos = ques_pos + 1'b1;
            end
            default: ;
        endcase

        if (offset != dqc_pkg::OFFSET_MAX) offset = offset + 1'b1;

        if (lst) begin
            if (phase == PH_FAILED) verdict = first_fail;
            else if (phase == PH_DONE) verdict = dqc_pkg::ST_OK;
            else verdict = end_code;
            v = '0;
            v.kind        = 1'b1;
            v.status      = verdict;
            v.query_type  = (verdict == dqc_pkg::ST_OK || verdict == dqc_pkg::ST_QTYPE ||
                             verdict == dqc_pkg::ST_QCLASS) ? type_hold : 16'h0000;
            v.name_length = name_count;
            v.last        = 1'b1;
            expected_results.push_back(v);
            clear_frame_state();
        end
    endtask

    task automatic compare_field(input string field, input logic [15:0] want,
                                 input logic [15:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            o_mismatches++;
        end
    endtask

    task automatic check_result(input dqc_pkg::t_out_item got);
        dqc_pkg::t_out_item want;
        if (expected_results.size() == 0) begin
            $display("%0t: result with nothing expected, expected none, actual %h",
                     $time, got);
            o_mismatches++;
        end else begin
            want = expected_results.pop_front();
            compare_field("kind", want.kind, got.kind);
            compare_field("name_char", want.name_char, got.name_char);
            compare_field("status", want.status, got.status);
            compare_field("query_type", want.query_type, got.query_type);
            compare_field("name_length", want.name_length, got.name_length);
            compare_field("last", want.last, got.last);
        end
        if (got.kind === 1'b1) begin
            o_frames++;
            o_status_seen[got.status] = 1'b1;
        end else begin
            o_chars++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            port_cfg = dqc_pkg::DNS_PORT_RESET;
            clear_frame_state();
            expected_results.delete();
            o_mismatches  = 0;
            o_frames      = 0;
            o_chars       = 0;
            o_status_seen = '0;
        end else begin
            if (i_out_valid && i_out_ready) check_result(i_out_data);
            if (i_in_valid && i_in_ready) classify_byte(i_in_data.frame_byte,
                                                         i_in_data.frame_last);
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr == DNS_PORT_ADDR)
                port_cfg = i_pwdata[15:0];
        end
        o_pending = expected_results.size();
    end

endmodule

// ----- dv/tb_dns_query_classifier.sv -----
// ----------------------------------------------------------------------------
// tb_dns_query_classifier
// Frame-level test of the DNS query classifier. Sends directed frames that
// hit every verdict, the name limit and the header and name truncation
// cases, then random well-formed and damaged queries under several DNS port
// settings, with random idle bursts on both channels. A checker module
// predicts and compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_dns_query_classifier;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [dqc_pkg::APB_ADDR_W-1:0] DNS_PORT_ADDR =
        dqc_pkg::APB_ADDR_W'(4 * dqc_pkg::REG_DNS_PORT);
    localparam logic [7:0] QR_MASK       = 8'(1 << (dqc_pkg::QR_BIT - 8));
    localparam int         NAME_AT       = dqc_pkg::OFS_DNS_END + 1; // first length byte
    localparam int         TOTAL_ITEMS   = 1900;
    localparam int         MIN_RANDOM    = 320;
    localparam int         SETTLE_CYCLES = 8;
    localparam int         TAIL_CYCLES   = 20;

    typedef enum int {
        FL_NONE,
        FL_ETHERTYPE,
        FL_PROTO,
        FL_PORT,
        FL_RESPONSE,
        FL_QDCOUNT,
        FL_QTYPE,
        FL_QCLASS,
        FL_TRUNCATE
    } t_frame_flaw;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           in_valid = 1'b0;
    dqc_pkg::t_in_item              in_item = '0;
    logic                           in_ready;
    logic                           out_valid;
    logic                           out_ready = 1'b1;
    dqc_pkg::t_out_item             out_item;
    logic                           psel = 1'b0;
    logic                           penable = 1'b0;
    logic                           pwrite = 1'b0;
    logic [dqc_pkg::APB_ADDR_W-1:0] paddr = '0;
    logic [dqc_pkg::APB_DATA_W-1:0] pwdata = '0;
    logic [dqc_pkg::APB_DATA_W-1:0] prdata;
    logic                           pready;

    int          mismatches;
    int          pending;
    int          frames_done;
    int          chars_done;
    logic [15:0] status_seen;

    bit          quiet = 1'b0;          // no idling at all in the final stretch
    bit          sender_idle = 1'b0;
    bit          receiver_idle = 1'b0;
    int          stall_left = 0;
    int          bytes_sent = 0;
    logic [15:0] cur_port = dqc_pkg::DNS_PORT_RESET;
    logic [7:0]  frame_bytes[$];
    int          label_plan[$];
    int          question_at;

    dns_query_classifier i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    dqc_result_checker i_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_in_data     (in_item),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_out_data    (out_item),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_pready      (pready),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .o_mismatches  (mismatches),
        .o_pending     (pending),
        .o_frames      (frames_done),
        .o_chars       (chars_done),
        .o_status_seen (status_seen)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Stall the result channel in random bursts; one update per
    // falling edge keeps ready stable across each rising edge.
    always @(negedge clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end else if (!quiet && receiver_idle && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 14);
            out_ready  <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    // Two-phase register write: setup, then access until pready.
    task automatic apb_write(input logic [dqc_pkg::APB_ADDR_W-1:0] addr,
                             input logic [dqc_pkg::APB_DATA_W-1:0] data);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = data;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Hold the byte channel until every queued result has arrived, then let
    // the pipeline empty of bytes that produce nothing.
    task automatic settle();
        in_valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_port(input logic [15:0] port);
        settle();
        apb_write(DNS_PORT_ADDR, {16'h0000, port});
        cur_port = port;
    endtask

    // Present one byte and wait for its transfer; drop valid during a gap.
    task automatic send_byte(input logic [7:0] b, input logic lst);
        int gap;
        if (!quiet && sender_idle && $urandom_range(0, 9) == 0) begin
            gap = $urandom_range(1, 15);
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        in_item  = '{frame_byte: b, frame_last: lst};
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
        bytes_sent++;
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame_bytes.size(); i++)
            send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
    endtask

    task automatic poke16(input int pos, input logic [15:0] v);
        frame_bytes[pos]     = v[15:8];
        frame_bytes[pos + 1] = v[7:0];
    endtask

    task automatic trim_to(input int n);
        while (frame_bytes.size() > n) frame_bytes.delete(frame_bytes.size() - 1);
    endtask

    // Build a well-formed query for the current port from label_plan.
    task automatic build_query(input logic [15:0] qtype);
        int n;
        frame_bytes.delete();
        for (int i = 0; i < NAME_AT; i++) frame_bytes.push_back(8'($urandom));
        poke16(dqc_pkg::OFS_ETYPE_HI, dqc_pkg::ETHERTYPE_IPV4);
        frame_bytes[dqc_pkg::OFS_PROTO] = dqc_pkg::PROTO_UDP[7:0];
        poke16(dqc_pkg::OFS_DPORT_HI, cur_port);
        frame_bytes[dqc_pkg::OFS_FLAGS_HI] = frame_bytes[dqc_pkg::OFS_FLAGS_HI] & ~QR_MASK;
        poke16(dqc_pkg::OFS_QDCNT_HI, dqc_pkg::QDCOUNT_ONE);
        n = 0;
        foreach (label_plan[k]) begin
            frame_bytes.push_back(8'(label_plan[k]));
            for (int c = 0; c < label_plan[k]; c++) frame_bytes.push_back(8'($urandom));
            n += label_plan[k] + 1;
        end
        // A name that fills the limit exactly has its next byte skipped, so
        // put junk there instead of the terminator.
        if (n == dqc_pkg::NAME_LIMIT) frame_bytes.push_back(8'($urandom));
        else frame_bytes.push_back(8'h00);
        question_at = frame_bytes.size();
        frame_bytes.push_back(qtype[15:8]);
        frame_bytes.push_back(qtype[7:0]);
        frame_bytes.push_back(dqc_pkg::QCLASS_IN[15:8]);
        frame_bytes.push_back(dqc_pkg::QCLASS_IN[7:0]);
    endtask

    task automatic apply_flaw(input t_frame_flaw flaw);
        logic [15:0] v;
        case (flaw)
            FL_ETHERTYPE: begin
                do v = 16'($urandom); while (v == dqc_pkg::ETHERTYPE_IPV4);
                poke16(dqc_pkg::OFS_ETYPE_HI, v);
            end
            FL_PROTO: begin
                do v = 16'($urandom_range(0, 255)); while (v == dqc_pkg::PROTO_UDP);
                frame_bytes[dqc_pkg::OFS_PROTO] = v[7:0];
            end
            FL_PORT: begin
                do v = 16'($urandom); while (v == cur_port);
                poke16(dqc_pkg::OFS_DPORT_HI, v);
            end
            FL_RESPONSE: frame_bytes[dqc_pkg::OFS_FLAGS_HI] =
                             frame_bytes[dqc_pkg::OFS_FLAGS_HI] | QR_MASK;
            FL_QDCOUNT: begin
                do v = 16'($urandom_range(0, 3) == 0 ? 0 : $urandom);
                while (v == dqc_pkg::QDCOUNT_ONE);
                poke16(dqc_pkg::OFS_QDCNT_HI, v);
            end
            FL_QTYPE: begin
                do v = 16'($urandom);
                while (v == dqc_pkg::QTYPE_A || v == dqc_pkg::QTYPE_AAAA);
                poke16(question_at, v);
            end
            FL_QCLASS: begin
                do v = 16'($urandom); while (v == dqc_pkg::QCLASS_IN);
                poke16(question_at + 2, v);
            end
            FL_TRUNCATE: begin
                // Cut anywhere half the time, else inside the name or question.
                if ($urandom_range(0, 1) == 0)
                    trim_to($urandom_range(1, frame_bytes.size() - 1));
                else
                    trim_to($urandom_range(NAME_AT + 1, frame_bytes.size() - 1));
            end
            default: ;
        endcase
    endtask

    // Mostly short labels, now and then a long one; stop once at the limit.
    task automatic make_random_plan();
        int total;
        int len;
        int count;
        label_plan.delete();
        total = 0;
        count = $urandom_range(0, 4);
        for (int i = 0; i < count; i++) begin
            len = ($urandom_range(0, 15) == 0) ? $urandom_range(1, 255) : $urandom_range(1, 12);
            label_plan.push_back(len);
            total += len + 1;
            if (total >= dqc_pkg::NAME_LIMIT) break;
        end
    endtask

    task automatic run_random_frame();
        int          pick;
        t_frame_flaw flaw;
        sender_idle   = $urandom_range(0, 3) != 0;
        receiver_idle = $urandom_range(0, 3) != 0;
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            // Line noise: random bytes of random length.
            frame_bytes.delete();
            repeat ($urandom_range(1, 70)) frame_bytes.push_back(8'($urandom));
        end else begin
            make_random_plan();
            build_query($urandom_range(0, 1) ? dqc_pkg::QTYPE_AAAA : dqc_pkg::QTYPE_A);
            if (pick < 55) flaw = FL_NONE;
            else flaw = t_frame_flaw'($urandom_range(FL_ETHERTYPE, FL_TRUNCATE));
            apply_flaw(flaw);
            if (flaw == FL_NONE && $urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 6)) frame_bytes.push_back(8'($urandom));
        end
        send_frame();
    endtask

    initial begin
        int cuts[6] = '{1, 4, 7, 8, 10, 11};
        int target;
        int budget;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed frames, reset port value.
        sender_idle   = 1'b1;
        receiver_idle = 1'b1;

        label_plan = '{3, 7, 3};
        build_query(dqc_pkg::QTYPE_A);
        send_frame();

        // Empty name: terminator right after the header.
        label_plan.delete();
        build_query(dqc_pkg::QTYPE_AAAA);
        send_frame();

        // Single-byte frame.
        frame_bytes.delete();
        frame_bytes.push_back(8'hFF);
        send_frame();

        // Ends before the ethertype is complete: short despite the bad value.
        label_plan = '{4};
        build_query(dqc_pkg::QTYPE_A);
        apply_flaw(FL_ETHERTYPE);
        trim_to(dqc_pkg::OFS_ETYPE_LO);
        send_frame();

        // Each header and question field failure on a full frame.
        for (int f = FL_ETHERTYPE; f <= FL_QCLASS; f++) begin
            label_plan = '{1};
            build_query(dqc_pkg::QTYPE_AAAA);
            apply_flaw(t_frame_flaw'(f));
            send_frame();
        end

        // Port failure counts once the UDP header is in, not before.
        label_plan = '{2};
        build_query(dqc_pkg::QTYPE_A);
        apply_flaw(FL_PORT);
        trim_to(dqc_pkg::OFS_UDP_END + 1);
        send_frame();
        build_query(dqc_pkg::QTYPE_A);
        apply_flaw(FL_PORT);
        trim_to(dqc_pkg::OFS_UDP_END);
        send_frame();

        // Truncation after a length byte, inside a label, at a label
        // boundary, on the terminator and inside the question.
        foreach (cuts[i]) begin
            label_plan = '{6};
            build_query(dqc_pkg::QTYPE_A);
            trim_to(NAME_AT + cuts[i]);
            send_frame();
        end

        // Name filling the limit exactly over two labels.
        label_plan = '{127, 127};
        build_query(dqc_pkg::QTYPE_A);
        send_frame();

        // Second label pushes the name past the limit; a few of its bytes
        // follow and must be ignored.
        label_plan = '{200, 60};
        build_query(dqc_pkg::QTYPE_A);
        trim_to(NAME_AT + 204);
        send_frame();

        // Port extremes.
        set_port(16'h0000);
        label_plan = '{1, 1};
        build_query(dqc_pkg::QTYPE_A);
        send_frame();
        apply_flaw(FL_PORT);
        send_frame();
        set_port(16'hFFFF);
        label_plan = '{9};
        build_query(dqc_pkg::QTYPE_AAAA);
        send_frame();

        // Random frames in four port settings; the port write between
        // settings also holds the sender until every result is in.
        budget = TOTAL_ITEMS - bytes_sent;
        if (budget < MIN_RANDOM) budget = MIN_RANDOM;
        for (int p = 0; p < 4; p++) begin
            if (p == 1) set_port(dqc_pkg::DNS_PORT_RESET);
            else set_port(16'($urandom));
            if (p == 3) quiet = 1'b1;
            target = bytes_sent + budget / 4;
            while (bytes_sent < target) run_random_frame();
        end

        // Drain, then give the verdict.
        in_valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);

        $display("Covered %0d frames, %0d name characters, %0d bytes under ports 0, 53, 65535",
                 frames_done, chars_done, bytes_sent);
        $display("and random values; verdict codes seen (bit per code): %b", status_seen);
        if (mismatches == 0 && pending == 0) begin
            $display("dns_query_classifier test passed");
        end else begin
            $display("dns_query_classifier test failed");
        end
        $finish;
    end

    // Stop a hung run.
    initial begin
        #15_000_000;
        $display("dns_query_classifier test failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/dqc_pkg.sv
hw/rtl/dqc_parser.sv
hw/rtl/dqc_out_queue.sv
hw/rtl/dns_query_classifier.sv
dv/dqc_result_checker.sv
dv/tb_dns_query_classifier.sv
